// ===== sv/s2i64_pkg.sv =====
// Shared types and constants for the string to int64 parser.
// No dependencies; imported by string_to_int64_parser, s2i64_checker and the testbench.
package s2i64_pkg;

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_SPACE  = 6'b000010,
        PH_START  = 6'b000100,
        PH_ZERO   = 6'b001000,
        PH_XSEEN  = 6'b010000,
        PH_DIGITS = 6'b100000
    } phase_t;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_NO_DIGITS = 2'd1;
    localparam status_t ST_RANGE     = 2'd2;
    localparam status_t ST_BAD_RADIX = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [5:0] RADIX_AUTO = 6'd0;
    localparam logic [5:0] RADIX_ONE  = 6'd1;
    localparam logic [5:0] RADIX_OCT  = 6'd8;
    localparam logic [5:0] RADIX_DEC  = 6'd10;
    localparam logic [5:0] RADIX_HEX  = 6'd16;
    localparam logic [5:0] RADIX_MAX  = 6'd36;
    localparam logic [5:0] NOT_DIGIT  = 6'd36;

    localparam logic [63:0] INT64_MAX_U = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT64_MIN_U = 64'h8000_0000_0000_0000;
    localparam logic [15:0] OFFSET_CAP  = 16'hFFFF;

endpackage

// ===== sv/string_to_int64_parser.sv =====
// strtoll-style parser: one character per transaction into a signed 64-bit value.
// Depends on s2i64_pkg (phase encoding, status codes, character constants).
//
//  channel | dir | tdata                            | tuser
//  s_      | in  | [7:0] ch                         | [0] first, [6:1] radix
//  m_      | out | [63:0] value, [79:64] end_offset | [1:0] status
//
// One transaction per cycle on the input while s_tready is high; each character
// is handled in the cycle it is accepted (one 64x6 multiply-add and compare into
// the state registers), and its result, if any, is registered in the output stage.
// Reset clears the parse state and both output stages.
// A two-entry output stage (output register plus skid) keeps s_tready high
// while a single result waits; s_tready drops only when both entries are full.
module string_to_int64_parser #(
    parameter int OFFSET_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic [6:0]  s_tuser,   // [0] first, [6:1] radix
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [63:0] value, [79:64] end_offset
    output logic [1:0]  m_tuser    // [1:0] status
);
    import s2i64_pkg::*;

    typedef logic [OFFSET_BITS-1:0] pos_t;

    function automatic logic [5:0] digit_of(input logic [7:0] c);
        logic [5:0] d;
        d = NOT_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE) d = 6'(c - CH_ZERO);
        else if (c >= CH_LA && c <= CH_LZ) d = 6'(c - CH_LA) + RADIX_DEC;
        else if (c >= CH_UA && c <= CH_UZ) d = 6'(c - CH_UA) + RADIX_DEC;
        return d;
    endfunction

    function automatic logic [15:0] sat_offset(input logic [63:0] p);
        return (p > 64'(OFFSET_CAP)) ? OFFSET_CAP : p[15:0];
    endfunction

    phase_t      phase_reg, phase_next;
    logic        neg_reg, neg_next;
    logic [5:0]  rad_reg, rad_next;
    logic [63:0] acc_reg, acc_next;
    logic        ovf_reg, ovf_next;
    logic        any_reg, any_next;
    pos_t        pos_reg, pos_next;

    logic        out_valid_reg, skid_valid_reg;
    logic [63:0] out_value_reg, skid_value_reg;
    logic [15:0] out_off_reg, skid_off_reg;
    status_t     out_st_reg, skid_st_reg;

    logic        accept;
    logic [7:0]  ch;
    logic        first;
    logic [5:0]  radix_in;
    logic [5:0]  dig;
    logic [69:0] mac;

    logic        res_valid;
    logic [63:0] res_value;
    logic [15:0] res_off;
    status_t     res_st;

    logic        bad, idle, start_path, take, from_acc, is_space;
    logic [63:0] limit;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign ch       = s_tdata;
    assign first    = s_tuser[0];
    assign radix_in = s_tuser[6:1];
    assign dig      = digit_of(ch);
    assign mac      = 70'(acc_reg) * 70'(rad_reg) + 70'(dig);
    assign is_space = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);

    always_comb begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        rad_next   = rad_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        any_next   = any_reg;
        pos_next   = pos_reg;
        res_valid  = 1'b0;
        res_value  = '0;
        res_off    = '0;
        res_st     = ST_OK;
        bad        = 1'b0;
        idle       = 1'b0;
        start_path = 1'b0;
        take       = 1'b0;
        from_acc   = (phase_reg == PH_DIGITS) && !first;
        limit      = '0;
        if (accept) begin
            if (first) begin
                rad_next = radix_in;
                neg_next = 1'b0;
                acc_next = '0;
                ovf_next = 1'b0;
                any_next = 1'b0;
                pos_next = '0;
                if (radix_in == RADIX_ONE || radix_in > RADIX_MAX) begin
                    bad        = 1'b1;
                    res_valid  = 1'b1;
                    res_st     = ST_BAD_RADIX;
                    phase_next = PH_IDLE;
                end else begin
                    phase_next = PH_SPACE;
                end
            end
            if (!bad) begin
                unique case (phase_next)
                    PH_SPACE: begin
                        if (is_space) begin
                        end else if (ch == CH_MINUS) begin
                            neg_next   = 1'b1;
                            phase_next = PH_START;
                        end else if (ch == CH_PLUS) begin
                            phase_next = PH_START;
                        end else begin
                            start_path = 1'b1;
                        end
                    end
                    PH_START: start_path = 1'b1;
                    PH_ZERO: begin
                        if (ch == CH_LX || ch == CH_UX) begin
                            acc_next   = 64'(pos_next);
                            phase_next = PH_XSEEN;
                        end else begin
                            if (rad_next == RADIX_AUTO) rad_next = RADIX_OCT;
                            take = 1'b1;
                        end
                    end
                    PH_XSEEN: begin
                        if (dig < RADIX_HEX) begin
                            rad_next = RADIX_HEX;
                            acc_next = '0;
                            take     = 1'b1;
                        end else begin
                            res_valid  = 1'b1;
                            res_st     = ST_OK;
                            res_off    = sat_offset(acc_next);
                            acc_next   = '0;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_DIGITS: take = 1'b1;
                    default: begin
                        idle       = 1'b1;
                        phase_next = PH_IDLE;
                    end
                endcase

                if (start_path) begin
                    if (ch == CH_ZERO && (rad_next == RADIX_AUTO || rad_next == RADIX_HEX)) begin
                        any_next   = 1'b1;
                        phase_next = PH_ZERO;
                    end else begin
                        if (rad_next == RADIX_AUTO) rad_next = RADIX_DEC;
                        take = 1'b1;
                    end
                end

                if (take) begin
                    limit = neg_next ? INT64_MIN_U : INT64_MAX_U;
                    if (dig >= rad_next || rad_next < 6'd2) begin
                        res_valid  = 1'b1;
                        phase_next = PH_IDLE;
                        if (!any_next) begin
                            res_st = ST_NO_DIGITS;
                        end else if (ovf_next) begin
                            res_st    = ST_RANGE;
                            res_value = neg_next ? INT64_MIN_U : INT64_MAX_U;
                            res_off   = sat_offset(64'(pos_next));
                        end else begin
                            res_st    = ST_OK;
                            res_value = neg_next ? (64'd0 - acc_next) : acc_next;
                            res_off   = sat_offset(64'(pos_next));
                        end
                    end else begin
                        if (!ovf_next) begin
                            if (from_acc && mac > 70'(limit)) ovf_next = 1'b1;
                            else acc_next = from_acc ? mac[63:0] : 64'(dig);
                        end
                        any_next   = 1'b1;
                        phase_next = PH_DIGITS;
                    end
                end

                if (!idle && pos_next != '1) pos_next = pos_next + pos_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            neg_reg   <= 1'b0;
            rad_reg   <= '0;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
            any_reg   <= 1'b0;
            pos_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            rad_reg   <= rad_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
            any_reg   <= any_next;
            pos_reg   <= pos_next;
        end
    end

    // output register with skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= res_valid;
            end
        end else if (res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_value_reg <= skid_value_reg;
                out_off_reg   <= skid_off_reg;
                out_st_reg    <= skid_st_reg;
            end else begin
                out_value_reg <= res_value;
                out_off_reg   <= res_off;
                out_st_reg    <= res_st;
            end
        end else if (res_valid) begin
            skid_value_reg <= res_value;
            skid_off_reg   <= res_off;
            skid_st_reg    <= res_st;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_off_reg, out_value_reg};
    assign m_tuser  = out_st_reg;

endmodule

// ===== sv/s2i64_checker.sv =====
// Port-level checks for string_to_int64_parser, attached by bind.
// Depends on s2i64_pkg (status codes).
module s2i64_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import s2i64_pkg::*;

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("output stages not empty after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_zero_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_NO_DIGITS || m_tuser == ST_BAD_RADIX) |-> m_tdata == '0)
        else $error("empty parse with nonzero value or offset");

    a_saturate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_RANGE
        |-> m_tdata[63:0] == INT64_MAX_U || m_tdata[63:0] == INT64_MIN_U)
        else $error("out of range result not saturated");

endmodule

bind string_to_int64_parser s2i64_checker u_s2i64_checker (.*);

// ===== test/tb_string_to_int64_parser.sv =====
// Self-checking testbench for string_to_int64_parser: streams strings one character per
// transaction, predicts each parse result, and checks every result field on the m_ channel.
// Depends on s2i64_pkg and the string_to_int64_parser RTL.
module tb_string_to_int64_parser;
    import s2i64_pkg::*;

    localparam logic [5:0] RADIX_BIN   = 6'd2;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_LIMIT = 5000;
    localparam int unsigned CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [63:0] value;
        status_t     status;
        logic [15:0] end_offset;
    } parse_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;    // [7:0] ch
    logic [6:0]  s_tuser = '0;    // [0] first, [6:1] radix
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;         // [63:0] value, [79:64] end_offset
    logic [1:0]  m_tuser;         // [1:0] status

    // shadow of the parser state
    phase_t      shadow_phase = PH_IDLE;
    logic        shadow_neg = 1'b0;
    logic [5:0]  shadow_radix = '0;
    logic [63:0] shadow_acc = '0;
    logic        shadow_ovf = 1'b0;
    logic        shadow_any = 1'b0;
    logic [15:0] shadow_pos = '0;

    parse_result_t expected_parses[$];
    logic [7:0]    text_buf[$];

    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned chars_sent = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned status_count[4] = '{0, 0, 0, 0};
    int unsigned cycle_count = 0;
    int unsigned hold_left = 0;
    logic        hold_req = 1'b0;

    string_to_int64_parser u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results pending", cycle_count,
                 expected_parses.size());
        $display("FAILED: results differ");
        $finish;
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        if (hold_req || hold_left > 1) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= $urandom_range(99) >= stall_pct;
        end
    end

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < 100) begin
            $display("mismatch in %s at result %0d: got %h, expected %h", field, results_seen,
                     got, want);
        end
        mismatches++;
    endtask

    always @(posedge aclk) begin : check_results
        parse_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            status_count[m_tuser]++;
            if (expected_parses.size() == 0) begin
                report_mismatch("unexpected transaction", m_tdata[63:0], '0);
            end else begin
                want = expected_parses.pop_front();
                if (m_tdata[63:0] !== want.value) begin
                    report_mismatch("value", m_tdata[63:0], want.value);
                end
                if (m_tuser !== want.status) begin
                    report_mismatch("status", 64'(m_tuser), 64'(want.status));
                end
                if (m_tdata[79:64] !== want.end_offset) begin
                    report_mismatch("end_offset", 64'(m_tdata[79:64]), 64'(want.end_offset));
                end
            end
            results_seen++;
        end
    end

    function automatic logic [5:0] char_digit(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return 6'(c - CH_ZERO);
        if (c >= CH_LA && c <= CH_LZ) return 6'(c - CH_LA + 8'd10);
        if (c >= CH_UA && c <= CH_UZ) return 6'(c - CH_UA + 8'd10);
        return NOT_DIGIT;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic void record_result(input logic [63:0] value, input status_t status,
                                          input logic [15:0] end_offset);
        expected_parses.push_back('{value: value, status: status, end_offset: end_offset});
        shadow_phase = PH_IDLE;
    endfunction

    function automatic void close_parse();
        if (!shadow_any) begin
            record_result('0, ST_NO_DIGITS, '0);
        end else if (shadow_ovf) begin
            record_result(shadow_neg ? INT64_MIN_U : INT64_MAX_U, ST_RANGE, shadow_pos);
        end else begin
            record_result(shadow_neg ? -shadow_acc : shadow_acc, ST_OK, shadow_pos);
        end
    endfunction

    function automatic void accept_digit(input logic [7:0] c);
        logic [63:0] d;
        logic [63:0] base;
        logic [63:0] limit;
        d = 64'(char_digit(c));
        base = 64'(shadow_radix);
        if (d >= base || shadow_radix < RADIX_BIN) begin
            close_parse();
            return;
        end
        limit = shadow_neg ? INT64_MIN_U : INT64_MAX_U;
        if (!shadow_ovf) begin
            if (shadow_acc > (limit - d) / base) begin
                shadow_ovf = 1'b1;
            end else begin
                shadow_acc = shadow_acc * base + d;
            end
        end
        shadow_any = 1'b1;
        shadow_phase = PH_DIGITS;
    endfunction

    function automatic void start_number(input logic [7:0] c);
        if (c == CH_ZERO && (shadow_radix == RADIX_AUTO || shadow_radix == RADIX_HEX)) begin
            shadow_any = 1'b1;
            shadow_phase = PH_ZERO;
        end else begin
            if (shadow_radix == RADIX_AUTO) shadow_radix = RADIX_DEC;
            accept_digit(c);
        end
    endfunction

    // expected effect of one accepted character
    function automatic void parse_char(input logic [7:0] c, input logic first,
                                       input logic [5:0] radix);
        if (first) begin
            shadow_radix = radix;
            shadow_neg = 1'b0;
            shadow_acc = '0;
            shadow_ovf = 1'b0;
            shadow_any = 1'b0;
            shadow_pos = '0;
            if (radix == RADIX_ONE || radix > RADIX_MAX) begin
                record_result('0, ST_BAD_RADIX, '0);
                return;
            end
            shadow_phase = PH_SPACE;
        end
        case (shadow_phase)
            PH_SPACE: begin
                if (c == CH_MINUS) begin
                    shadow_neg = 1'b1;
                    shadow_phase = PH_START;
                end else if (c == CH_PLUS) begin
                    shadow_phase = PH_START;
                end else if (!is_blank(c)) begin
                    start_number(c);
                end
            end
            PH_START: start_number(c);
            PH_ZERO: begin
                if (c == CH_LX || c == CH_UX) begin
                    shadow_acc = 64'(shadow_pos);   // index of the x
                    shadow_phase = PH_XSEEN;
                end else begin
                    if (shadow_radix == RADIX_AUTO) shadow_radix = RADIX_OCT;
                    accept_digit(c);
                end
            end
            PH_XSEEN: begin
                if (char_digit(c) < RADIX_HEX) begin
                    shadow_radix = RADIX_HEX;
                    shadow_acc = '0;
                    accept_digit(c);
                end else begin
                    record_result('0, ST_OK, shadow_acc[15:0]);
                    shadow_acc = '0;
                end
            end
            PH_DIGITS: accept_digit(c);
            default: return;
        endcase
        if (shadow_pos != OFFSET_CAP) shadow_pos++;
    endfunction

    function automatic logic [7:0] digit_char(input logic [5:0] d);
        if (d < RADIX_DEC) return CH_ZERO + 8'(d);
        return ($urandom_range(1) ? CH_LA : CH_UA) + 8'(d) - 8'd10;
    endfunction

    function automatic void render_digits(input logic [63:0] mag, input logic [5:0] base);
        logic [7:0]  digits[$];
        logic [63:0] b;
        b = 64'(base);
        do begin
            digits.push_front(digit_char(6'(mag % b)));
            mag = mag / b;
        end while (mag != 0);
        foreach (digits[i]) text_buf.push_back(digits[i]);
    endfunction

    function automatic logic [7:0] pick_terminator();
        logic [7:0] c;
        c = 8'($urandom);
        if ($urandom_range(1)) return c;
        while (char_digit(c) != NOT_DIGIT || c == CH_MINUS || c == CH_PLUS || is_blank(c))
            c = 8'($urandom);
        return c;
    endfunction

    task automatic send_char(input logic [7:0] ch, input logic first, input logic [5:0] radix);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= {radix, first};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (first || shadow_phase != PH_IDLE) chars_sent++;
        parse_char(ch, first, radix);
    endtask

    task automatic send_literal(input string s, input logic [5:0] radix);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0, radix);
    endtask

    task automatic send_text(input logic [5:0] radix, input int unsigned count);
        for (int i = 0; i < count; i++) send_char(text_buf[i], i == 0, radix);
    endtask

    task automatic finish_string();
        while (shadow_phase != PH_IDLE) send_char(pick_terminator(), 1'b0, 6'($urandom));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && expected_parses.size() != 0; n++) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic build_number(output logic [5:0] radix);
        logic [5:0]  base;
        logic [63:0] mag;
        int unsigned pick;
        int unsigned mode;
        text_buf.delete();
        repeat ($urandom_range(0, 2))
            text_buf.push_back($urandom_range(0, 5) == 0 ? CH_SPACE
                               : CH_TAB + 8'($urandom_range(0, 4)));
        pick = $urandom_range(0, 3);
        if (pick == 0) text_buf.push_back(CH_MINUS);
        else if (pick == 1) text_buf.push_back(CH_PLUS);
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2: begin
                radix = RADIX_AUTO;
                base = pick == 0 ? RADIX_DEC : (pick == 1 ? RADIX_OCT : RADIX_HEX);
                if (base != RADIX_DEC) text_buf.push_back(CH_ZERO);
                if (base == RADIX_HEX) text_buf.push_back($urandom_range(1) ? CH_LX : CH_UX);
            end
            3, 4: begin
                radix = RADIX_HEX;
                base = RADIX_HEX;
                if (pick == 4) begin
                    text_buf.push_back(CH_ZERO);
                    text_buf.push_back($urandom_range(1) ? CH_LX : CH_UX);
                end
            end
            5: base = RADIX_DEC;
            6: base = RADIX_BIN;
            7: base = RADIX_OCT;
            8: base = RADIX_MAX;
            default: base = 6'($urandom_range(2, 36));
        endcase
        if (pick > 4) radix = base;
        mode = $urandom_range(0, 4);
        case (mode)
            0: mag = 64'($urandom_range(0, 999));
            1: mag = INT64_MAX_U - 64'd2 + 64'($urandom_range(0, 4));
            2: mag = {$urandom, $urandom} >> $urandom_range(0, 63);
            3: mag = {$urandom, $urandom};
            default: mag = 64'($urandom_range(0, 35));
        endcase
        render_digits(mag, base);
        if (mode == 3) begin
            repeat ($urandom_range(1, 2))
                text_buf.push_back(digit_char(6'($urandom_range(0, base - 1))));
        end
    endtask

    task automatic test_directed();
        idle_pct = 0;
        stall_pct = 0;
        send_char(8'hFF, 1'b0, 6'h3F);                 // ignored while idle
        send_char(8'h00, 1'b1, RADIX_AUTO);            // no digits
        send_char(CH_ZERO + 8'd7, 1'b1, RADIX_ONE);    // invalid radix
        send_char(CH_ZERO + 8'd7, 1'b1, RADIX_MAX + 6'd1);
        send_literal("-!", RADIX_DEC);                 // sign only
        send_literal(" 0xg", RADIX_AUTO);              // prefix without hex digit
        send_literal("12", RADIX_DEC);                 // dropped by restart
        send_literal("Zz.", RADIX_MAX);
        send_literal("\t+0X1f ", RADIX_HEX);
        send_literal("0179", RADIX_AUTO);              // auto octal, 9 ends it
        wait_drained();
    endtask

    // saturation edges in random bases
    task automatic test_limits();
        logic [5:0] base;
        idle_pct = 10;
        stall_pct = 10;
        repeat (3) begin
            base = 6'($urandom_range(2, 36));
            for (int k = 0; k < 6; k++) begin
                text_buf.delete();
                if (k >= 3) text_buf.push_back(CH_MINUS);
                render_digits(INT64_MAX_U + 64'(k % 3), base);
                send_text(base, text_buf.size());
                finish_string();
            end
        end
        wait_drained();
    endtask

    task automatic test_random_strings(input int unsigned send_idle, input int unsigned sink_stall,
                                       input int unsigned quota);
        int unsigned start_chars;
        int unsigned pick;
        logic [5:0]  radix;
        idle_pct = send_idle;
        stall_pct = sink_stall;
        start_chars = chars_sent;
        while (chars_sent - start_chars < quota) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                repeat ($urandom_range(1, 3)) send_char(8'($urandom), 1'b0, 6'($urandom));
            end else if (pick < 14) begin
                send_char(8'($urandom), 1'b1,
                          $urandom_range(0, 3) == 0 ? RADIX_ONE : 6'($urandom_range(37, 63)));
            end else if (pick < 24) begin
                text_buf.delete();
                repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom));
                send_text(6'($urandom), text_buf.size());
                finish_string();
            end else begin
                build_number(radix);
                if (pick < 32) begin
                    send_text(radix, $urandom_range(1, text_buf.size()));
                end else begin
                    send_text(radix, text_buf.size());
                    finish_string();
                end
            end
        end
        finish_string();
        wait_drained();
    endtask

    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        hold_req <= 1'b1;
        @(posedge aclk);
        hold_req <= 1'b0;
        repeat (40) begin
            send_char(CH_ZERO + 8'($urandom_range(0, 9)), 1'b1, RADIX_DEC);
            finish_string();
        end
        wait_drained();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_limits();
        test_random_strings(0, 0, 120);
        test_random_strings(50, 0, 120);
        test_random_strings(0, 50, 120);
        test_random_strings(26, 26, 120);
        test_backpressure();
        wait_drained();
        if (expected_parses.size() != 0) begin
            report_mismatch("results never delivered", 64'(expected_parses.size()), '0);
        end
        $display("%0d characters parsed into %0d results in %0d cycles", chars_sent,
                 results_seen, cycle_count);
        $display("status mix: ok %0d, no digits %0d, out of range %0d, bad radix %0d",
                 status_count[ST_OK], status_count[ST_NO_DIGITS], status_count[ST_RANGE],
                 status_count[ST_BAD_RADIX]);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== string_to_int64_parser.f =====
sv/s2i64_pkg.sv
sv/string_to_int64_parser.sv
sv/s2i64_checker.sv
test/tb_string_to_int64_parser.sv
